// File: hw/rtl/pwl_pkg.sv
package pwl_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_OUTSIDE = 3'd2,
    ST_DUP     = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_REDUCE,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_SHIFT,
    FSM_MUL,
    FSM_DIV,
    FSM_FINISH,
    FSM_OUT
  } fsm_e;

  localparam int unsigned REG_PERIODIC = 0;
  localparam int unsigned REG_PERIOD   = 1;

  // command from sequencer to the cell row
  typedef struct packed {
    logic        shift_en;  // every cell above slot takes its lower neighbor
    logic        write_en;  // slot cell takes new point
  } cell_cmd_t;

endpackage

// File: hw/rtl/pwl_cell.sv
module pwl_cell
  import pwl_pkg::*;
#(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned MY_IDX = 0
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] slot_i,
  input  logic [31:0]      new_x_i,
  input  logic [31:0]      new_y_i,
  input  logic [31:0]      prev_x_i,
  input  logic [31:0]      prev_y_i,
  output logic [31:0]      x_o,
  output logic [31:0]      y_o
);

  logic [31:0] x_q, y_q;
  logic        at_slot, above;

  assign at_slot = (slot_i == IDX_W'(MY_IDX));
  assign above   = (IDX_W'(MY_IDX) > slot_i);

  // insertion: cells above slot take neighbor, slot cell takes new point
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en && at_slot) begin
      x_q <= new_x_i;
      y_q <= new_y_i;
    end else if (cmd_i.shift_en && above) begin
      x_q <= prev_x_i;
      y_q <= prev_y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// File: hw/rtl/piecewise_linear_table_interp.sv
// channel | direction | signals                                   | accept
// in      | input     | in_valid_i in_stall_o action x y          | valid & !stall
// out     | output    | out_valid_o out_stall_i y_result pos ...  | valid & !stall
// cfg     | input     | cfg_valid_i cfg_ready_o cfg_index cfg_data | valid & ready
// one item at a time; an add runs the scan of the cell row, decide, insert and output,
// an interpolating evaluate the scan, decide, a 33x33 multiply in four partial
// products, a 128-step restoring divider and output; clear, unused action code and
// evaluate of an empty table go straight to output
// the 32-step periodic reduction runs before the scan when periodic mode is on
// reset clears count and control, sets periodic off and period 1.0; table stays undefined
// a finished result waits in the output register while the next item is taken
module piecewise_linear_table_interp
  import pwl_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] y_result_o,
  output logic [5:0]         position_o,
  output logic [6:0]         point_total_o,
  output logic [2:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // configuration
  logic        periodic_q;
  logic [30:0] period_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= 1'b0;
      period_q   <= 31'(64'd1 << FRAC_BITS);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 1'(REG_PERIODIC)) periodic_q <= cfg_data_i[0];
      else period_q <= cfg_data_i;
    end
  end

  // cell row
  cell_cmd_t        cmd;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [31:0]      cx [DEPTH];
  logic [31:0]      cy [DEPTH];
  logic [31:0]      ax_q, ay_q;  // item operands

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pwl_cell #(.IDX_W(IDX_W), .MY_IDX(g)) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .slot_i   (slot_q),
      .new_x_i  (ax_q),
      .new_y_i  (ay_q),
      .prev_x_i ((g == 0) ? cx[0] : cx[(g == 0) ? 0 : g-1]),
      .prev_y_i ((g == 0) ? cy[0] : cy[(g == 0) ? 0 : g-1]),
      .x_o      (cx[g]),
      .y_o      (cy[g])
    );
  end

  // sequencer state
  fsm_e state_q, state_d;
  logic [1:0]       act_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] scan_q;   // scan pointer, ends at first slot with abscissa >= x, or at count
  logic [31:0]      px_q, py_q;  // point just below the scan pointer
  logic [7:0]       step_q;
  // reduction: 32-step restoring remainder of |x| by period
  logic [31:0]      rrem_q;
  logic [31:0]      rnum_q;
  logic             rneg_q;
  // interpolation operands
  logic signed [33:0] x1_q, y1_q, x2_q, y2_q;
  logic [32:0]        a_q, b_q;     // magnitudes
  logic [33:0]        d_q;
  logic               neg_q;
  logic [127:0]       prod_q;
  logic [127:0]       num_q;
  logic [33:0]        rem_q;
  logic [127:0]       quo_q;
  logic signed [31:0] yres_q;
  logic [IDX_W-1:0]   pos_q;
  status_e            stat_q;

  logic        in_acc, out_acc;
  logic [31:0] eff_period;
  assign eff_period = (period_q == '0) ? 32'd1 : {1'b0, period_q};
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != FSM_IDLE);

  logic            scan_end;
  logic [IDX_W-1:0] scan_idx, last_idx;
  assign scan_idx = scan_q[IDX_W-1:0];
  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign scan_end = (scan_q >= count_q) ||
                    !($signed(cx[scan_idx]) < $signed(ax_q));

  logic signed [33:0] tx1, ty1, tx2, ty2, sspan, sdx, sdy;

  // next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:   if (in_acc) begin
        if (action_i == ACT_CLEAR || action_i == ACT_NONE) state_d = FSM_OUT;
        else if (action_i == ACT_EVAL && count_q == '0) state_d = FSM_OUT;
        else if (periodic_q) state_d = FSM_REDUCE;
        else state_d = FSM_SCAN;
      end
      FSM_REDUCE: if (step_q == 8'd32) state_d = FSM_SCAN;
      FSM_SCAN:   if (scan_end) state_d = FSM_DECIDE;
      FSM_DECIDE: state_d = FSM_SHIFT;
      // a non-positive span answers with y1 and skips the divider
      FSM_SHIFT:  state_d = (act_q == ACT_EVAL && stat_q == ST_OK &&
                             step_q == 8'd1 && sspan > 34'sd0) ? FSM_MUL : FSM_OUT;
      FSM_MUL:    if (step_q == 8'd4) state_d = FSM_DIV;
      FSM_DIV:    if (step_q == 8'd128) state_d = FSM_FINISH;
      FSM_FINISH: state_d = FSM_OUT;
      FSM_OUT:    if (!out_valid_o || out_acc) state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  // output logic
  always_comb begin
    cmd = '0;
    slot_d = slot_q;
    if (state_q == FSM_DECIDE) slot_d = scan_idx;
    if (state_q == FSM_SHIFT && act_q == ACT_ADD && stat_q == ST_OK) begin
      cmd.shift_en = 1'b1;
      cmd.write_en = 1'b1;
    end
  end

  logic [31:0]        rtrial;
  logic [32:0]        rsub;
  logic [34:0]        dsub;
  logic [33:0]        drem_sh;
  logic [63:0]        pp;
  logic [127:0]       qcap;
  logic signed [42:0] ysum;

  always_comb begin
    rtrial = {rrem_q[30:0], rnum_q[31]};
    rsub   = {1'b0, rtrial} - {1'b0, eff_period};
    drem_sh = {rem_q[32:0], num_q[127]};
    dsub   = {1'b0, drem_sh} - {1'b0, d_q};
    // segment end points
    tx1 = 34'(signed'(px_q));
    ty1 = 34'(signed'(py_q));
    tx2 = 34'(signed'(cx[scan_idx]));
    ty2 = 34'(signed'(cy[scan_idx]));
    if (scan_q == '0) begin
      tx1 = 34'(signed'(cx[last_idx])) - 34'(signed'({1'b0, eff_period}));
      ty1 = 34'(signed'(cy[last_idx]));
    end else if (scan_q >= count_q) begin
      tx1 = 34'(signed'(cx[last_idx]));
      ty1 = 34'(signed'(cy[last_idx]));
      tx2 = 34'(signed'(cx[0])) + 34'(signed'({1'b0, eff_period}));
      ty2 = 34'(signed'(cy[0]));
    end
    sspan = x2_q - x1_q;
    sdx   = 34'(signed'(ax_q)) - x1_q;
    sdy   = y2_q - y1_q;
    case (step_q[1:0])
      2'd0:    pp = 64'(a_q[31:0]) * 64'(b_q[31:0]);
      2'd1:    pp = 64'(a_q[31:0]) * 64'(b_q[32]);
      2'd2:    pp = 64'(a_q[32]) * 64'(b_q[31:0]);
      default: pp = 64'(a_q[32] & b_q[32]);
    endcase
    qcap = ((quo_q[127:41] != '0) || (quo_q[40:0] > 41'h100_0000_0000)) ?
           128'h100_0000_0000 : quo_q;
    ysum = 43'(y1_q) + (neg_q ? -43'(qcap[40:0]) : 43'(qcap[40:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_o <= 1'b0;
      slot_q      <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if (out_acc && state_q != FSM_OUT) out_valid_o <= 1'b0;
      case (state_q)
        FSM_IDLE: if (in_acc) begin
          act_q  <= action_i;
          ax_q   <= x_value_i;
          ay_q   <= y_value_i;
          step_q <= '0;
          scan_q <= '0;
          yres_q <= '0;
          pos_q  <= '0;
          stat_q <= (action_i == ACT_EVAL && count_q == '0) ? ST_EMPTY : ST_OK;
          rrem_q <= '0;
          rneg_q <= x_value_i[31];
          rnum_q <= x_value_i[31] ? 32'(-x_value_i) : x_value_i;
          if (action_i == ACT_CLEAR) count_q <= '0;
        end
        FSM_REDUCE: begin
          if (step_q == 8'd32) begin
            // floor modulo from magnitude remainder
            ax_q <= (rneg_q && rrem_q != '0) ? eff_period - rrem_q : rrem_q;
          end else begin
            rrem_q <= rsub[32] ? rtrial : rsub[31:0];
            rnum_q <= {rnum_q[30:0], 1'b0};
            step_q <= step_q + 8'd1;
          end
        end
        FSM_SCAN: if (!scan_end) begin
          scan_q <= scan_q + CNT_W'(1);
          px_q   <= cx[scan_idx];
          py_q   <= cy[scan_idx];
        end
        FSM_DECIDE: begin
          x1_q <= tx1; y1_q <= ty1; x2_q <= tx2; y2_q <= ty2;
          if (act_q == ACT_ADD) begin
            step_q <= '0;
            if (scan_q < count_q && cx[scan_idx] == ax_q) stat_q <= ST_DUP;
            else if (count_q >= CNT_W'(DEPTH)) stat_q <= ST_FULL;
            else pos_q <= scan_idx;
          end else begin
            if (!periodic_q && ($signed(ax_q) < $signed(cx[0]) ||
                $signed(ax_q) > $signed(cx[last_idx]))) begin
              stat_q <= ST_OUTSIDE;
              step_q <= '0;
            end else if (scan_q < count_q && cx[scan_idx] == ax_q) begin
              yres_q <= cy[scan_idx];
              step_q <= '0;
            end else step_q <= 8'd1;  // needs interpolation
          end
        end
        FSM_SHIFT: begin
          if (act_q == ACT_ADD && stat_q == ST_OK) count_q <= count_q + CNT_W'(1);
          neg_q  <= (sdx < 0) != (sdy < 0);
          a_q    <= 33'(sdx < 0 ? -sdx : sdx);
          b_q    <= 33'(sdy < 0 ? -sdy : sdy);
          d_q    <= sspan;
          prod_q <= '0;
          if (step_q == 8'd1 && sspan <= 0) begin
            step_q <= '0;
            yres_q <= (y1_q > 34'sd2147483647) ? 32'h7fffffff :
                      (y1_q < -34'sd2147483648) ? 32'h80000000 : 32'(y1_q);
          end else step_q <= '0;
          if (step_q == 8'd1 && sspan <= 0) stat_q <= ST_OK;
        end
        FSM_MUL: begin
          if (step_q == 8'd4) begin
            num_q  <= prod_q;
            rem_q  <= '0;
            quo_q  <= '0;
            step_q <= '0;
          end else begin
            case (step_q[1:0])
              2'd0:    prod_q <= prod_q + 128'(pp);
              2'd3:    prod_q <= prod_q + (128'(pp) << 64);
              default: prod_q <= prod_q + (128'(pp) << 32);
            endcase
            step_q <= step_q + 8'd1;
          end
        end
        FSM_DIV: if (step_q != 8'd128) begin
          rem_q  <= dsub[34] ? drem_sh : dsub[33:0];
          quo_q  <= {quo_q[126:0], !dsub[34]};
          num_q  <= {num_q[126:0], 1'b0};
          step_q <= step_q + 8'd1;
        end
        FSM_FINISH: yres_q <= (ysum > 43'sd2147483647) ? 32'h7fffffff :
                              (ysum < -43'sd2147483648) ? 32'h80000000 : 32'(ysum);
        FSM_OUT: if (!out_valid_o || out_acc) begin
          out_valid_o   <= 1'b1;
          y_result_o    <= yres_q;
          position_o    <= 6'(pos_q);
          point_total_o <= 7'(count_q);
          status_o      <= stat_q;
        end
        default: ;
      endcase
    end
  end

  // while busy the input is stalled
  property p_busy_stall;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != FSM_IDLE) |-> in_stall_o;
  endproperty
  a_busy_stall: assert property (p_busy_stall) else $error("busy but not stalled");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("count overflow");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == '0 ||
    count_q == $past(count_q) + CNT_W'(1))) else $error("bad count change");

endmodule
